>>> src/nearest_neighbor_scaler_addr_gen_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor scaler address generator
// Property wrappers used by nns_dp, the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_SCALER_ADDR_GEN_TOP_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALER_ADDR_GEN_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NNS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nns assertion failed");

// next-cycle implication, disabled during reset
`define NNS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nns assertion failed");

`endif

>>> src/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg
// Types, constants and helpers shared by the scaler address generator.
// ----------------------------------------------------------------------------
package nns_pkg;

  localparam int DIM_W      = 13;  // dimension registers, coordinates, remainders
  localparam int COORD_W    = 12;  // coordinate output fields
  localparam int QUOT_W     = 12;  // source coordinate accumulators
  localparam int BPP_W      = 2;
  localparam int BASE_W     = 32;
  localparam int ADDR_OUT_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_DIM_DEF    = 4096;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BASE   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SCL,
    ST_OUT
  } nns_state_t;

  typedef struct packed {
    logic div_start;  // launch step divisions
    logic step_load;  // latch steps, clear position
    logic mul_en;     // form pixel indexes
    logic scl_en;     // scale indexes by bytes per pixel
    logic out_load;   // load result register, advance position
  } nns_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } nns_sts_t;

  // zero reads as 1, oversize clamps to max_dim
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input int unsigned max_dim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > max_dim) begin
      r = DIM_W'(max_dim);
    end
    return r;
  endfunction

endpackage

>>> src/nns_div.sv
// ----------------------------------------------------------------------------
// nns_div
// Restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module nns_div #(
  parameter int W = nns_pkg::DIM_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dvd_r, dvd_nxt;
  logic [W-1:0]     dsr_r, dsr_nxt;
  logic [W:0]       trial;
  logic [W:0]       diff;

  always_comb begin
    trial    = {rem_r, dvd_r[W-1]};
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> src/nns_dp.sv
// ----------------------------------------------------------------------------
// nns_dp
// Datapath: configuration, position accumulators, index math, result register.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_scaler_addr_gen_top_defines.svh"

module nns_dp #(
  parameter int MAX_DIM    = nns_pkg::MAX_DIM_DEF,
  parameter int ADDR_WIDTH = nns_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  nns_pkg::nns_cmd_t                cmd,
  output nns_pkg::nns_sts_t                sts,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [87:0]                      out_tdata,
  output logic                             out_tlast
);

  localparam int DW = nns_pkg::DIM_W;
  localparam int QW = nns_pkg::QUOT_W;
  localparam int CW = nns_pkg::COORD_W;
  localparam int AW = nns_pkg::ADDR_OUT_W;
  localparam int SIDX_W = QW + DW + 1;
  localparam int DIDX_W = 2 * DW + 1;
  localparam int SSCL_W = SIDX_W + 2;
  localparam int DSCL_W = DIDX_W + 2;
  localparam logic [AW-1:0] ADDR_MASK =
    (ADDR_WIDTH >= AW) ? {AW{1'b1}} : ((AW'(1) << ADDR_WIDTH) - AW'(1));

  // configuration
  logic [DW-1:0]                  src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [nns_pkg::BPP_W-1:0]      bpp_r;
  logic [nns_pkg::BASE_W-1:0]     src_base_r, dst_base_r;

  // position state
  logic [DW-1:0] out_col_r, out_col_nxt;
  logic [DW-1:0] out_row_r, out_row_nxt;
  logic [QW-1:0] src_col_quot_r, src_col_quot_nxt;
  logic [DW-1:0] src_col_rem_r, src_col_rem_nxt;
  logic [QW-1:0] src_row_quot_r, src_row_quot_nxt;
  logic [DW-1:0] src_row_rem_r, src_row_rem_nxt;
  logic [DW-1:0] step_x_quot_r, step_x_rem_r, step_y_quot_r, step_y_rem_r;

  logic [SIDX_W-1:0] sidx_r;
  logic [DIDX_W-1:0] didx_r;
  logic [SSCL_W-1:0] sscl_r;
  logic [DSCL_W-1:0] dscl_r;

  logic [AW-1:0] out_src_r, out_dst_r;
  logic [CW-1:0] out_x_r, out_y_r;
  logic          out_last_r;
  logic          out_valid_r, out_valid_nxt;

  logic [DW-1:0] sw, sh, dw, dh;
  logic [1:0]    bpp;
  logic          col_wrap, row_wrap, last_px;
  logic [DW:0]   col_rem_sum, row_rem_sum;

  logic          done_x, done_y;
  logic [DW-1:0] quo_x, rem_x, quo_y, rem_y;

  assign sw  = nns_pkg::eff_dim(src_w_r, MAX_DIM);
  assign sh  = nns_pkg::eff_dim(src_h_r, MAX_DIM);
  assign dw  = nns_pkg::eff_dim(dst_w_r, MAX_DIM);
  assign dh  = nns_pkg::eff_dim(dst_h_r, MAX_DIM);
  assign bpp = (bpp_r == '0) ? 2'd1 : bpp_r;

  nns_div #(.W(DW)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (sw),
    .divisor   (dw),
    .done      (done_x),
    .quotient  (quo_x),
    .remainder (rem_x)
  );

  nns_div #(.W(DW)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (sh),
    .divisor   (dh),
    .done      (done_y),
    .quotient  (quo_y),
    .remainder (rem_y)
  );

  assign sts.div_done = done_x;
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r    <= DW'(1);
      src_h_r    <= DW'(1);
      dst_w_r    <= DW'(1);
      dst_h_r    <= DW'(1);
      bpp_r      <= 2'd3;
      src_base_r <= '0;
      dst_base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nns_pkg::REG_SRC_WIDTH:  src_w_r    <= cfg_data[DW-1:0];
        nns_pkg::REG_SRC_HEIGHT: src_h_r    <= cfg_data[DW-1:0];
        nns_pkg::REG_DST_WIDTH:  dst_w_r    <= cfg_data[DW-1:0];
        nns_pkg::REG_DST_HEIGHT: dst_h_r    <= cfg_data[DW-1:0];
        nns_pkg::REG_BPP:        bpp_r      <= cfg_data[nns_pkg::BPP_W-1:0];
        nns_pkg::REG_SRC_BASE:   src_base_r <= cfg_data[nns_pkg::BASE_W-1:0];
        nns_pkg::REG_DST_BASE:   dst_base_r <= cfg_data[nns_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // position advance, one conditional subtract on the remainder
  always_comb begin
    col_wrap    = ({1'b0, out_col_r} + (DW+1)'(1)) >= {1'b0, dw};
    row_wrap    = ({1'b0, out_row_r} + (DW+1)'(1)) >= {1'b0, dh};
    last_px     = col_wrap && row_wrap;
    col_rem_sum = {1'b0, src_col_rem_r} + {1'b0, step_x_rem_r};
    row_rem_sum = {1'b0, src_row_rem_r} + {1'b0, step_y_rem_r};

    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    src_col_quot_nxt = src_col_quot_r;
    src_col_rem_nxt  = src_col_rem_r;
    src_row_quot_nxt = src_row_quot_r;
    src_row_rem_nxt  = src_row_rem_r;

    if (cmd.step_load) begin
      out_col_nxt      = '0;
      out_row_nxt      = '0;
      src_col_quot_nxt = '0;
      src_col_rem_nxt  = '0;
      src_row_quot_nxt = '0;
      src_row_rem_nxt  = '0;
    end else if (cmd.out_load) begin
      if (col_wrap) begin
        out_col_nxt      = '0;
        src_col_quot_nxt = '0;
        src_col_rem_nxt  = '0;
        if (row_wrap) begin
          out_row_nxt      = '0;
          src_row_quot_nxt = '0;
          src_row_rem_nxt  = '0;
        end else begin
          out_row_nxt = out_row_r + DW'(1);
          if (row_rem_sum >= {1'b0, dh}) begin
            src_row_rem_nxt  = DW'(row_rem_sum - {1'b0, dh});
            src_row_quot_nxt = src_row_quot_r + step_y_quot_r[QW-1:0] + QW'(1);
          end else begin
            src_row_rem_nxt  = row_rem_sum[DW-1:0];
            src_row_quot_nxt = src_row_quot_r + step_y_quot_r[QW-1:0];
          end
        end
      end else begin
        out_col_nxt = out_col_r + DW'(1);
        if (col_rem_sum >= {1'b0, dw}) begin
          src_col_rem_nxt  = DW'(col_rem_sum - {1'b0, dw});
          src_col_quot_nxt = src_col_quot_r + step_x_quot_r[QW-1:0] + QW'(1);
        end else begin
          src_col_rem_nxt  = col_rem_sum[DW-1:0];
          src_col_quot_nxt = src_col_quot_r + step_x_quot_r[QW-1:0];
        end
      end
    end

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_col_r      <= '0;
      out_row_r      <= '0;
      src_col_quot_r <= '0;
      src_col_rem_r  <= '0;
      src_row_quot_r <= '0;
      src_row_rem_r  <= '0;
      step_x_quot_r  <= '0;
      step_x_rem_r   <= '0;
      step_y_quot_r  <= '0;
      step_y_rem_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_col_r      <= out_col_nxt;
      out_row_r      <= out_row_nxt;
      src_col_quot_r <= src_col_quot_nxt;
      src_col_rem_r  <= src_col_rem_nxt;
      src_row_quot_r <= src_row_quot_nxt;
      src_row_rem_r  <= src_row_rem_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cmd.step_load) begin
        step_x_quot_r <= quo_x;
        step_x_rem_r  <= rem_x;
        step_y_quot_r <= quo_y;
        step_y_rem_r  <= rem_y;
      end
    end
  end

  // index pipeline: multiply, scale, add base
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      sidx_r <= SIDX_W'(src_row_quot_r) * SIDX_W'(sw) + SIDX_W'(src_col_quot_r);
      didx_r <= DIDX_W'(out_row_r) * DIDX_W'(dw) + DIDX_W'(out_col_r);
    end
    if (cmd.scl_en) begin
      sscl_r <= (bpp[1] ? {1'b0, sidx_r, 1'b0} : SSCL_W'(0)) +
                (bpp[0] ? SSCL_W'(sidx_r) : SSCL_W'(0));
      dscl_r <= (bpp[1] ? {1'b0, didx_r, 1'b0} : DSCL_W'(0)) +
                (bpp[0] ? DSCL_W'(didx_r) : DSCL_W'(0));
    end
    if (cmd.out_load) begin
      out_src_r  <= (AW'(src_base_r) + AW'(sscl_r)) & ADDR_MASK;
      out_dst_r  <= (AW'(dst_base_r) + AW'(dscl_r)) & ADDR_MASK;
      out_x_r    <= out_col_r[CW-1:0];
      out_y_r    <= out_row_r[CW-1:0];
      out_last_r <= last_px;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r, out_dst_r, out_src_r};
  assign out_tlast  = out_last_r;

  `NNS_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.out_load, sts.out_free)
  `NNS_ASSERT_IMP(a_div_lockstep, clk, rst_n, done_x || done_y, done_x && done_y)
  `NNS_ASSERT_NXT(a_result_shown, clk, rst_n, cmd.out_load, out_tvalid)
  `NNS_ASSERT_NXT(a_restart_origin, clk, rst_n, cmd.step_load,
                  out_col_r == '0 && out_row_r == '0)

endmodule

>>> src/nns_ctrl.sv
// ----------------------------------------------------------------------------
// nns_ctrl
// Sequencer: accept, optional step division, index math, result load.
// ----------------------------------------------------------------------------
module nns_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              restart,
  input  nns_pkg::nns_sts_t sts,
  output nns_pkg::nns_cmd_t cmd
);

  nns_pkg::nns_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nns_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      nns_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (restart) begin
            cmd.div_start = 1'b1;
            state_nxt     = nns_pkg::ST_DIV;
          end else begin
            state_nxt = nns_pkg::ST_MUL;
          end
        end
      end
      nns_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.step_load = 1'b1;
          state_nxt     = nns_pkg::ST_MUL;
        end
      end
      nns_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = nns_pkg::ST_SCL;
      end
      nns_pkg::ST_SCL: begin
        cmd.scl_en = 1'b1;
        state_nxt  = nns_pkg::ST_OUT;
      end
      nns_pkg::ST_OUT: begin
        // hold until the result register can take a new pixel
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = nns_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nns_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/nearest_neighbor_scaler_addr_gen_top.sv
// Nearest-neighbor scaler address generator. Each input transfer yields one
// result transfer for the next destination pixel in raster order, wrapping
// to (0,0) after the last one; restart = 1 returns to (0,0) and recomputes
// the source steps. For each pixel the controller walks multiply, byte
// scaling and result load in turn; result load waits until the result
// register is free, and a restart first runs the 13-bit iterative step
// divider. The result register lets a new item be accepted while a result
// is still waiting downstream. Configure only while idle.
// ----------------------------------------------------------------------------
// nearest_neighbor_scaler_addr_gen_top
// Top level: controller plus datapath on stream and config ports.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_addr_gen_top #(
  parameter int MAX_DIM    = nns_pkg::MAX_DIM_DEF,
  parameter int ADDR_WIDTH = nns_pkg::ADDR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [0] restart
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] src_address, [63:32] dst_address, [75:64] dst_x, [87:76] dst_y
  output logic [87:0]                    out_tdata,
  output logic                           out_tlast   // frame_last
);

  nns_pkg::nns_cmd_t cmd;
  nns_pkg::nns_sts_t sts;

  nns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .restart   (in_tdata[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  nns_dp #(
    .MAX_DIM    (MAX_DIM),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
